// ===== sv/xor_parity_fec_engine_defines.svh =====
// ----------------------------------------------------------------------------
// xor_parity_fec_engine_defines.svh
// Assertion macros used by the checker file of the parity FEC engine.
// ----------------------------------------------------------------------------
`ifndef XOR_PARITY_FEC_ENGINE_DEFINES_SVH
`define XOR_PARITY_FEC_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define XPFEC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("xpfec assertion failed");

// Next-cycle implication, disabled during reset.
`define XPFEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("xpfec assertion failed");

// Next-cycle implication that also holds across reset.
`define XPFEC_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("xpfec assertion failed");

`endif

// ===== sv/xpfec_pkg.sv =====
// ----------------------------------------------------------------------------
// xpfec_pkg
// Types, constants and helper functions of the XOR parity FEC engine.
// ----------------------------------------------------------------------------
`default_nettype none

package xpfec_pkg;

    // Field widths
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned IDX_W    = 11;
    localparam int unsigned BCNT_W   = 3;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned PCNT_W   = 15;
    localparam int unsigned TALLY_W  = 16;
    localparam int unsigned HDR_W    = 11;
    localparam int unsigned PAY_W    = 14;
    localparam int unsigned CFG_DW   = 14;
    localparam int unsigned CFG_IW   = 1;
    localparam int unsigned REGION_W = 13;
    localparam int unsigned CMP_W    = 16;

    // Store depth default
    localparam int unsigned STORE_WORDS_DEF = 2048;

    // Config reset values
    localparam logic [HDR_W-1:0] HDR_RST = 11'd12;
    localparam logic [PAY_W-1:0] PAY_RST = 14'd1500;

    // Config register indexes
    localparam logic [CFG_IW-1:0] CFG_HEADER  = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_PAYLOAD = 1'b1;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_LOAD  = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        RS_NONE        = 2'd0,
        RS_READY       = 2'd1,
        RS_MISS_DATA   = 2'd2,
        RS_MISS_PARITY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic commit;
        logic sweep_en;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_clear;
        logic sweep_last;
    } t_stat;

    // Keep only the valid low bytes of a word
    function automatic logic [WORD_W-1:0] byte_mask(input logic [BCNT_W-1:0] cnt);
        logic [WORD_W-1:0] m;
        case (cnt)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Restore status from the signed tally
    function automatic t_status status_of(input logic [TALLY_W-1:0] tally);
        t_status s;
        if (tally == '0) begin
            s = RS_NONE;
        end else if (tally == '1) begin
            s = RS_READY;
        end else if (tally[TALLY_W-1]) begin
            s = RS_MISS_DATA;
        end else begin
            s = RS_MISS_PARITY;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== sv/xpfec_ram.sv =====
// ----------------------------------------------------------------------------
// xpfec_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module xpfec_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2048,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/xpfec_ctrl.sv =====
// ----------------------------------------------------------------------------
// xpfec_ctrl
// Controller of the parity FEC engine: input and output handshake, item
// sequencing and the store clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module xpfec_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire xpfec_pkg::t_stat i_stat,
    output xpfec_pkg::t_cmd       o_cmd
);

    xpfec_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    // State and output-valid registers; reset starts a clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xpfec_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_in_stall     = 1'b1;
        o_cmd.accept   = 1'b0;
        o_cmd.commit   = 1'b0;
        o_cmd.sweep_en = 1'b0;
        case (r_state)
            xpfec_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = xpfec_pkg::ST_EXEC;
                end
            end
            xpfec_pkg::ST_EXEC: begin
                // store read data is ready; commit once the result slot frees
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = i_stat.is_clear ? xpfec_pkg::ST_CLEAR
                                                   : xpfec_pkg::ST_IDLE;
                end
            end
            xpfec_pkg::ST_CLEAR: begin
                o_cmd.sweep_en = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = xpfec_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = xpfec_pkg::ST_IDLE;
            end
        endcase
    end

    // Result beat held until taken
    assign n_out_valid = o_cmd.commit || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== sv/xpfec_dpath.sv =====
// ----------------------------------------------------------------------------
// xpfec_dpath
// Datapath of the parity FEC engine: config registers, word store with
// read-modify-write, tally and length parity, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module xpfec_dpath #(
    parameter int unsigned STORE_WORDS = xpfec_pkg::STORE_WORDS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire xpfec_pkg::t_cmd                   i_cmd,
    output xpfec_pkg::t_stat                       o_stat,
    input  wire logic                              i_cfg_we,
    input  wire logic [xpfec_pkg::CFG_IW-1:0]      i_cfg_index,
    input  wire logic [xpfec_pkg::CFG_DW-1:0]      i_cfg_data,
    input  wire logic [1:0]                        i_action,
    input  wire logic [xpfec_pkg::IDX_W-1:0]       i_word_index,
    input  wire logic [xpfec_pkg::WORD_W-1:0]      i_data_word,
    input  wire logic [xpfec_pkg::BCNT_W-1:0]      i_byte_count,
    input  wire logic                              i_last_word,
    input  wire logic [xpfec_pkg::LEN_W-1:0]       i_packet_len,
    input  wire logic [xpfec_pkg::PCNT_W-1:0]      i_parity_count,
    output logic [xpfec_pkg::WORD_W-1:0]           o_read_word,
    output logic signed [xpfec_pkg::TALLY_W-1:0]   o_packet_count,
    output logic [xpfec_pkg::LEN_W-1:0]            o_length_xor,
    output logic [1:0]                             o_restore_status,
    output logic                                   o_index_error
);

    localparam int unsigned AW = $clog2(STORE_WORDS);
    localparam logic [AW-1:0] SWEEP_LAST = AW'(STORE_WORDS - 1);
    localparam logic [xpfec_pkg::CMP_W-1:0] DEPTH_CMP = xpfec_pkg::CMP_W'(STORE_WORDS);

    // Config registers
    logic [xpfec_pkg::HDR_W-1:0] r_hdr_bytes;
    logic [xpfec_pkg::PAY_W-1:0] r_pay_bytes;

    // Latched item
    xpfec_pkg::t_action           r_action;
    logic [AW-1:0]                r_addr;
    logic [xpfec_pkg::WORD_W-1:0] r_data;
    logic                         r_last;
    logic [xpfec_pkg::LEN_W-1:0]  r_plen;
    logic [xpfec_pkg::PCNT_W-1:0] r_pcount;
    logic                         r_in_range;

    // Running state
    logic [xpfec_pkg::TALLY_W-1:0] r_tally, n_tally;
    logic [xpfec_pkg::LEN_W-1:0]   r_lpar, n_lpar;
    logic [AW-1:0]                 r_sweep;

    // Result register
    logic [xpfec_pkg::WORD_W-1:0]  r_rword;
    logic [xpfec_pkg::TALLY_W-1:0] r_count;
    logic [xpfec_pkg::LEN_W-1:0]   r_lxor;
    xpfec_pkg::t_status            r_status;
    logic                          r_ierr;

    // Store ports
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [xpfec_pkg::WORD_W-1:0] ram_wdata;
    logic [xpfec_pkg::WORD_W-1:0] ram_rdata;

    logic [xpfec_pkg::PAY_W:0]    pay_round;
    logic [xpfec_pkg::REGION_W-1:0] region;
    logic                         in_range;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_bytes <= xpfec_pkg::HDR_RST;
            r_pay_bytes <= xpfec_pkg::PAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                xpfec_pkg::CFG_HEADER:  r_hdr_bytes <= i_cfg_data[xpfec_pkg::HDR_W-1:0];
                xpfec_pkg::CFG_PAYLOAD: r_pay_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Region check: header words plus rounded-up payload words, capped by depth
    assign pay_round = {1'b0, r_pay_bytes} + (xpfec_pkg::PAY_W + 1)'(3);
    assign region    = {4'd0, r_hdr_bytes[xpfec_pkg::HDR_W-1:2]}
                     + pay_round[xpfec_pkg::PAY_W:2];
    assign in_range  = ({2'd0, i_word_index} < region)
                    && ({5'd0, i_word_index} < DEPTH_CMP);

    // Latch the item on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action   <= xpfec_pkg::t_action'(i_action);
            r_addr     <= AW'(i_word_index);
            r_data     <= i_data_word & xpfec_pkg::byte_mask(i_byte_count);
            r_last     <= i_last_word;
            r_plen     <= i_packet_len;
            r_pcount   <= i_parity_count;
            r_in_range <= in_range;
        end
    end

    // Tally and length parity update
    always_comb begin
        n_tally = r_tally;
        n_lpar  = r_lpar;
        case (r_action)
            xpfec_pkg::ACT_CLEAR: begin
                n_tally = '0;
                n_lpar  = '0;
            end
            xpfec_pkg::ACT_ADD: begin
                if (r_last) begin
                    n_tally = r_tally + 16'd1;
                    n_lpar  = r_lpar ^ r_plen;
                end
            end
            xpfec_pkg::ACT_LOAD: begin
                if (r_last) begin
                    n_tally = 16'd0 - {1'b0, r_pcount};
                    n_lpar  = r_plen;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
            r_lpar  <= '0;
        end else if (i_cmd.commit) begin
            r_tally <= n_tally;
            r_lpar  <= n_lpar;
        end
    end

    // Clearing sweep counter, back to zero after the last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_en) begin
            r_sweep <= (r_sweep == SWEEP_LAST) ? '0 : r_sweep + AW'(1);
        end
    end

    // Store write: sweep zeroes, add XORs, load overwrites
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = r_data;
        if (i_cmd.sweep_en) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep;
            ram_wdata = '0;
        end else if (i_cmd.commit && r_in_range) begin
            case (r_action)
                xpfec_pkg::ACT_ADD: begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata ^ r_data;
                end
                xpfec_pkg::ACT_LOAD: begin
                    ram_we = 1'b1;
                end
                default: ;
            endcase
        end
    end

    xpfec_ram #(
        .WIDTH (xpfec_pkg::WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (AW'(i_word_index)),
        .o_rdata (ram_rdata)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rword  <= (r_action == xpfec_pkg::ACT_READ && r_in_range) ? ram_rdata : '0;
            r_count  <= n_tally;
            r_lxor   <= n_lpar;
            r_status <= xpfec_pkg::status_of(n_tally);
            r_ierr   <= (r_action != xpfec_pkg::ACT_CLEAR) && !r_in_range;
        end
    end

    assign o_read_word      = r_rword;
    assign o_packet_count   = r_count;
    assign o_length_xor     = r_lxor;
    assign o_restore_status = r_status;
    assign o_index_error    = r_ierr;

    assign o_stat.is_clear   = (r_action == xpfec_pkg::ACT_CLEAR);
    assign o_stat.sweep_last = (r_sweep == SWEEP_LAST);

endmodule

`default_nettype wire

// ===== sv/xor_parity_fec_engine.sv =====
// ----------------------------------------------------------------------------
// xor_parity_fec_engine
// XOR parity forward error correction over packets of 32-bit words.
//
//   channel   direction  handshake              beat
//   in        input      i_in_valid/o_in_stall  one add/clear/load/read item
//   out       output     o_out_valid/i_out_stall one result per item
//   cfg       input      i_cfg_valid/o_cfg_ready register index and data
//
// An item takes two steps: accept, which issues the store read, then the
// read-modify-write commit into the result register.
// The commit waits while a previous result is still stalled on the output.
// Clear adds a sweep over all STORE_WORDS store words, one store word per
// cycle, with the input stalled; reset starts the same sweep.
// Reset is synchronous, active low; config is taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_parity_fec_engine #(
    parameter int unsigned STORE_WORDS = xpfec_pkg::STORE_WORDS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input items
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [1:0]                        i_action,
    input  wire logic [xpfec_pkg::IDX_W-1:0]       i_word_index,
    input  wire logic [xpfec_pkg::WORD_W-1:0]      i_data_word,
    input  wire logic [xpfec_pkg::BCNT_W-1:0]      i_byte_count,
    input  wire logic                              i_last_word,
    input  wire logic [xpfec_pkg::LEN_W-1:0]       i_packet_len,
    input  wire logic [xpfec_pkg::PCNT_W-1:0]      i_parity_count,
    // results
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [xpfec_pkg::WORD_W-1:0]           o_read_word,
    output logic signed [xpfec_pkg::TALLY_W-1:0]   o_packet_count,
    output logic [xpfec_pkg::LEN_W-1:0]            o_length_xor,
    output logic [1:0]                             o_restore_status,
    output logic                                   o_index_error,
    // config writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [xpfec_pkg::CFG_IW-1:0]      i_cfg_index,
    input  wire logic [xpfec_pkg::CFG_DW-1:0]      i_cfg_data
);

    xpfec_pkg::t_cmd  cmd;
    xpfec_pkg::t_stat stat;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    xpfec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    xpfec_dpath #(
        .STORE_WORDS (STORE_WORDS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_word_index     (i_word_index),
        .i_data_word      (i_data_word),
        .i_byte_count     (i_byte_count),
        .i_last_word      (i_last_word),
        .i_packet_len     (i_packet_len),
        .i_parity_count   (i_parity_count),
        .o_read_word      (o_read_word),
        .o_packet_count   (o_packet_count),
        .o_length_xor     (o_length_xor),
        .o_restore_status (o_restore_status),
        .o_index_error    (o_index_error)
    );

endmodule

`default_nettype wire

// ===== sv/xpfec_checker.sv =====
// ----------------------------------------------------------------------------
// xpfec_checker
// Port-level checks of the parity FEC engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xor_parity_fec_engine_defines.svh"

module xpfec_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic signed [xpfec_pkg::TALLY_W-1:0] o_packet_count,
    input wire logic [1:0]                      o_restore_status
);

    logic ready_beat;

    // result beat that reports a packet ready to restore
    assign ready_beat = o_out_valid && (o_restore_status == xpfec_pkg::RS_READY);

    // a stalled result beat stays offered
    `XPFEC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    // reset launches the clearing sweep, so input is stalled right after
    `XPFEC_ASSERT_NEXT_ALWAYS(a_rst_stall, !i_rst_n, o_in_stall)

    // an accepted item occupies the engine for its commit cycle
    `XPFEC_ASSERT_NEXT(a_accept_busy, i_in_valid && !o_in_stall, o_in_stall)

    // ready status only with a tally of minus one
    `XPFEC_ASSERT_NOW(a_ready_tally, ready_beat, o_packet_count == -16'sd1)

endmodule

bind xor_parity_fec_engine xpfec_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_packet_count   (o_packet_count),
    .o_restore_status (o_restore_status)
);

`default_nettype wire

// ===== test/xor_parity_fec_engine_test.sv =====
// ----------------------------------------------------------------------------
// xor_parity_fec_engine_test
// Self-checking bench for the XOR parity FEC engine. A queue of items, first
// a directed set and then encode and decode packet groups with random
// content plus random noise, feeds a bursty driver. A predictor keeps its
// own copy of the word store, tally, length parity and region registers, so
// the expected result of each accepted item is known. A monitor compares
// every result beat field by field, while the output stalls on a pattern of
// its own. The region registers are rewritten between phases, extremes
// included.
// ----------------------------------------------------------------------------
module xor_parity_fec_engine_test;

    import xpfec_pkg::*;

    localparam int unsigned CLK_PERIOD     = 20;
    localparam int unsigned RESET_CYCLES   = 12;
    localparam int unsigned STORE_DEPTH    = STORE_WORDS_DEF;
    localparam int unsigned SETTLE_CYCLES  = 20;
    localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
    localparam int unsigned NUM_PHASES     = 8;
    localparam int unsigned MAX_PRINTED    = 100;

    // One input item
    typedef struct {
        t_action             act;
        logic [IDX_W-1:0]    idx;
        logic [WORD_W-1:0]   data;
        logic [BCNT_W-1:0]   bcnt;
        logic                last;
        logic [LEN_W-1:0]    plen;
        logic [PCNT_W-1:0]   pcnt;
        logic                drain_first;
    } t_fec_item;

    // One result beat
    typedef struct {
        logic [WORD_W-1:0]   word;
        logic [TALLY_W-1:0]  tally;
        logic [LEN_W-1:0]    lpar;
        t_status             status;
        logic                ierr;
    } t_fec_result;

    // DUT signals
    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_stall;
    logic [1:0]             i_action       = '0;
    logic [IDX_W-1:0]       i_word_index   = '0;
    logic [WORD_W-1:0]      i_data_word    = '0;
    logic [BCNT_W-1:0]      i_byte_count   = '0;
    logic                   i_last_word    = 1'b0;
    logic [LEN_W-1:0]       i_packet_len   = '0;
    logic [PCNT_W-1:0]      i_parity_count = '0;
    logic                   o_out_valid;
    logic                   i_out_stall    = 1'b0;
    logic [WORD_W-1:0]      o_read_word;
    logic signed [TALLY_W-1:0] o_packet_count;
    logic [LEN_W-1:0]       o_length_xor;
    logic [1:0]             o_restore_status;
    logic                   o_index_error;
    logic                   i_cfg_valid    = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IW-1:0]      i_cfg_index    = '0;
    logic [CFG_DW-1:0]      i_cfg_data     = '0;

    // Predictor state
    logic [WORD_W-1:0]      parity_store [STORE_DEPTH];
    logic [TALLY_W-1:0]     fec_tally  = '0;
    logic [LEN_W-1:0]       len_parity = '0;
    logic [HDR_W-1:0]       hdr_bytes  = HDR_RST;
    logic [PAY_W-1:0]       pay_bytes  = PAY_RST;

    // Bench bookkeeping
    t_fec_item              item_queue[$];
    t_fec_result            expected_results[$];
    t_fec_item              cur_item;
    t_fec_result            want;
    logic                   drain_next    = 1'b0;
    int unsigned            items_queued  = 0;
    int unsigned            results_seen  = 0;
    int unsigned            error_count   = 0;
    int unsigned            burst_left    = 0;
    int unsigned            gap_left      = 0;
    int unsigned            stall_run     = 0;
    int unsigned            free_run      = 0;
    int unsigned            stall_cap     = 0;
    int unsigned            mode_left     = 0;

    xor_parity_fec_engine u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_word_index     (i_word_index),
        .i_data_word      (i_data_word),
        .i_byte_count     (i_byte_count),
        .i_last_word      (i_last_word),
        .i_packet_len     (i_packet_len),
        .i_parity_count   (i_parity_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_read_word      (o_read_word),
        .o_packet_count   (o_packet_count),
        .o_length_xor     (o_length_xor),
        .o_restore_status (o_restore_status),
        .o_index_error    (o_index_error),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Clock
    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Header words plus payload words, clipped to the store depth
    function automatic int unsigned store_region_words();
        int unsigned w;
        w = int'(hdr_bytes >> 2) + ((int'(pay_bytes) + 3) / 4);
        return (w < STORE_DEPTH) ? w : STORE_DEPTH;
    endfunction

    // Apply one item to the predicted state and return its result beat
    function automatic t_fec_result predict_fec_result(input t_fec_item it);
        t_fec_result       r;
        logic [WORD_W-1:0] masked;
        logic              hit;
        hit = int'(it.idx) < store_region_words();
        case (it.bcnt)
            3'd0:    masked = '0;
            3'd1:    masked = {24'h0, it.data[7:0]};
            3'd2:    masked = {16'h0, it.data[15:0]};
            3'd3:    masked = {8'h0, it.data[23:0]};
            default: masked = it.data;
        endcase
        r.word = '0;
        r.ierr = (it.act != ACT_CLEAR) && !hit;
        case (it.act)
            ACT_CLEAR: begin
                for (int i = 0; i < STORE_DEPTH; i++) parity_store[i] = '0;
                fec_tally  = '0;
                len_parity = '0;
            end
            ACT_ADD: begin
                if (hit) parity_store[it.idx] = parity_store[it.idx] ^ masked;
                if (it.last) begin
                    fec_tally  = fec_tally + 16'd1;
                    len_parity = len_parity ^ it.plen;
                end
            end
            ACT_LOAD: begin
                if (hit) parity_store[it.idx] = masked;
                if (it.last) begin
                    fec_tally  = 16'd0 - {1'b0, it.pcnt};
                    len_parity = it.plen;
                end
            end
            default: begin
                if (hit) r.word = parity_store[it.idx];
            end
        endcase
        r.tally = fec_tally;
        r.lpar  = len_parity;
        if (fec_tally == '0) begin
            r.status = RS_NONE;
        end else if (fec_tally == '1) begin
            r.status = RS_READY;
        end else if (fec_tally[TALLY_W-1]) begin
            r.status = RS_MISS_DATA;
        end else begin
            r.status = RS_MISS_PARITY;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH beat %0d %s: got 0x%0h expected 0x%0h",
                     results_seen, what, got, exp_val);
        error_count++;
    endtask

    // Driver: bursts with random gaps, optional pause until drained
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(predict_fec_result(cur_item));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (item_queue.size() != 0 &&
                             !(item_queue[0].drain_first && expected_results.size() != 0)) begin
                    cur_item = item_queue.pop_front();
                    i_action       <= cur_item.act;
                    i_word_index   <= cur_item.idx;
                    i_data_word    <= cur_item.data;
                    i_byte_count   <= cur_item.bcnt;
                    i_last_word    <= cur_item.last;
                    i_packet_len   <= cur_item.plen;
                    i_parity_count <= cur_item.pcnt;
                    i_in_valid     <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat, and drive the output stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("beat with nothing expected", o_read_word, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_read_word !== want.word)
                        report_mismatch("read_word", o_read_word, want.word);
                    if (o_packet_count !== want.tally)
                        report_mismatch("packet_count", 32'(unsigned'(o_packet_count)),
                                        32'(want.tally));
                    if (o_length_xor !== want.lpar)
                        report_mismatch("length_xor", 32'(o_length_xor), 32'(want.lpar));
                    if (o_restore_status !== want.status)
                        report_mismatch("restore_status", 32'(o_restore_status),
                                        32'(want.status));
                    if (o_index_error !== want.ierr)
                        report_mismatch("index_error", 32'(o_index_error), 32'(want.ierr));
                end
                results_seen++;
            end
            // stall mode is picked anew when its countdown runs out; cap 0 means no stalls
            if (mode_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_cap = 0;
                    1:       stall_cap = 2;
                    default: stall_cap = 8;
                endcase
                mode_left = $urandom_range(300, 800);
            end else begin
                mode_left--;
            end
            if (stall_run != 0) begin
                stall_run--;
                i_out_stall <= 1'b1;
            end else if (free_run != 0) begin
                free_run--;
                i_out_stall <= 1'b0;
            end else begin
                stall_run = (stall_cap == 0) ? 0 : $urandom_range(0, stall_cap);
                free_run  = $urandom_range(0, 12);
                i_out_stall <= (stall_run != 0);
            end
        end
    end

    task automatic push_item(input t_action act, input int unsigned idx,
                             input logic [WORD_W-1:0] data, input int unsigned bcnt,
                             input logic last, input logic [LEN_W-1:0] plen,
                             input logic [PCNT_W-1:0] pcnt);
        t_fec_item it;
        it.act         = act;
        it.idx         = IDX_W'(idx);
        it.data        = data;
        it.bcnt        = BCNT_W'(bcnt);
        it.last        = last;
        it.plen        = plen;
        it.pcnt        = pcnt;
        it.drain_first = drain_next;
        drain_next     = 1'b0;
        item_queue.push_back(it);
        items_queued++;
    endtask

    // Mostly full words, sometimes short, empty or oversized counts
    function automatic int unsigned pick_byte_count();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(5, 7);
        if (r < 5) return $urandom_range(1, 3);
        return 4;
    endfunction

    // One packet: consecutive words from base, last_word on the final one
    task automatic gen_packet(input t_action act, input int unsigned base,
                              input int unsigned nwords, input logic [PCNT_W-1:0] pcnt);
        logic [LEN_W-1:0] plen;
        int unsigned      bcnt;
        plen = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom) : LEN_W'(nwords * 4);
        for (int w = 0; w < nwords; w++) begin
            bcnt = (w == nwords - 1 || $urandom_range(0, 7) == 0) ? pick_byte_count() : 4;
            push_item(act, base + w, $urandom, bcnt, w == nwords - 1, plen, pcnt);
        end
    endtask

    task automatic gen_noise_item();
        t_action act;
        case ($urandom_range(0, 31))
            0:       act = ACT_CLEAR;
            1, 2, 3,
            4, 5, 6,
            7, 8, 9,
            10:      act = ACT_ADD;
            11, 12, 13,
            14, 15:  act = ACT_LOAD;
            default: act = ACT_READ;
        endcase
        push_item(act, $urandom_range(0, 2047), $urandom, $urandom_range(0, 7),
                  1'($urandom_range(0, 1)), LEN_W'($urandom), PCNT_W'($urandom));
    endtask

    // A group of packets: encode, decode with usually one lost packet, or noise
    task automatic gen_episode(input bit force_drain);
        int unsigned region, nwords, npk, nrecv, base;
        logic [PCNT_W-1:0] pcnt;
        region     = store_region_words();
        npk        = $urandom_range(1, 5);
        nwords     = $urandom_range(1, 6);
        drain_next = force_drain || ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 7))
            0:       base = (region >= 2) ? region - 2 : 0;
            1:       base = $urandom_range(0, 2047);
            default: base = (region > nwords) ? $urandom_range(0, region - nwords) : 0;
        endcase
        if ($urandom_range(0, 4) == 0)
            push_item(ACT_CLEAR, $urandom_range(0, 2047), $urandom, $urandom_range(0, 7),
                      1'($urandom_range(0, 1)), LEN_W'($urandom), PCNT_W'($urandom));
        case ($urandom_range(0, 5))
            0, 1: begin
                for (int p = 0; p < npk; p++) gen_packet(ACT_ADD, base, nwords, '0);
                for (int w = 0; w < nwords; w++)
                    push_item(ACT_READ, base + w, $urandom, 4, 1'b0, '0, '0);
            end
            2, 3, 4: begin
                pcnt  = ($urandom_range(0, 5) == 0) ? PCNT_W'($urandom) : PCNT_W'(npk);
                nrecv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, npk) : npk - 1;
                gen_packet(ACT_LOAD, base, nwords, pcnt);
                for (int p = 0; p < nrecv; p++) gen_packet(ACT_ADD, base, nwords, '0);
                for (int w = 0; w < nwords; w++)
                    push_item(ACT_READ, base + w, $urandom, 4, 1'b0, '0, '0);
            end
            default: begin
                repeat ($urandom_range(4, 12)) gen_noise_item();
            end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DW'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HEADER) hdr_bytes = HDR_W'(value);
        else pay_bytes = PAY_W'(value);
    endtask

    task automatic wait_idle();
        while (item_queue.size() != 0 || expected_results.size() != 0 || i_in_valid)
            @(posedge i_clk);
    endtask

    // Stimulus and end of run
    initial begin
        int unsigned hdr_set [NUM_PHASES];
        int unsigned pay_set [NUM_PHASES];
        int unsigned phase_start, target, episodes;
        hdr_set = '{0, 1024, 1024, 0, 12, 16, 6, 1024};
        pay_set = '{0, 8192, 0, 8192, 1500, 64, 37, 5};
        episodes = 0;
        for (int i = 0; i < STORE_DEPTH; i++) parity_store[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed set, run on the reset region of 378 words
        push_item(ACT_READ,  0,    '0,           4, 1'b0, '0,       '0);
        push_item(ACT_ADD,   0,    32'hFFFFFFFF, 4, 1'b0, '0,       '0);
        push_item(ACT_ADD,   0,    32'hA5A5A5A5, 0, 1'b0, '0,       '0);
        push_item(ACT_ADD,   1,    32'h12345678, 1, 1'b0, '0,       '0);
        push_item(ACT_ADD,   2,    32'h9ABCDEF0, 2, 1'b0, '0,       '0);
        push_item(ACT_ADD,   3,    32'h0F1E2D3C, 3, 1'b0, '0,       '0);
        push_item(ACT_ADD,   4,    32'hFFFFFFFF, 7, 1'b1, 16'hFFFF, 15'h7FFF);
        push_item(ACT_ADD,   2047, 32'h55AA55AA, 4, 1'b1, 16'h1234, '0);
        for (int w = 0; w < 5; w++) push_item(ACT_READ, w, '0, 4, 1'b0, '0, '0);
        push_item(ACT_READ,  377,  '0,           4, 1'b0, '0,       '0);
        push_item(ACT_READ,  378,  '0,           4, 1'b0, '0,       '0);
        push_item(ACT_LOAD,  377,  32'hDEADBEEF, 5, 1'b0, '0,       '0);
        push_item(ACT_READ,  377,  '0,           4, 1'b0, '0,       '0);
        // tally to -32767, then zero, then ready, then wrap to zero and beyond
        push_item(ACT_LOAD,  5,    '0,           4, 1'b1, '0,       15'h7FFF);
        push_item(ACT_LOAD,  2000, 32'hFFFFFFFF, 4, 1'b1, 16'hFFFF, '0);
        push_item(ACT_LOAD,  6,    32'h00C0FFEE, 4, 1'b1, 16'hABCD, 15'd1);
        push_item(ACT_ADD,   7,    32'h11111111, 4, 1'b1, 16'h00FF, '0);
        push_item(ACT_ADD,   8,    32'h22222222, 4, 1'b1, '0,       '0);
        push_item(ACT_CLEAR, 2047, 32'hFFFFFFFF, 7, 1'b1, 16'hFFFF, 15'h7FFF);
        push_item(ACT_READ,  0,    '0,           4, 1'b0, '0,       '0);
        push_item(ACT_READ,  2047, '0,           4, 1'b0, '0,       '0);

        // random phases, one region setting each
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            write_reg(CFG_HEADER, hdr_set[ph]);
            write_reg(CFG_PAYLOAD, pay_set[ph]);
            target      = (ph == 0) ? 80 : 230;
            phase_start = items_queued;
            while (items_queued - phase_start < target) begin
                gen_episode(episodes == 1);
                episodes++;
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout after %0d results", results_seen);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
